// ----- src/alm_pkg.sv -----
// Shared types, codes and saturating arithmetic for the audio level meter.
package alm_pkg;

  typedef enum logic [1:0] {
    REQ_SAMPLE   = 2'd0,
    REQ_SILENT   = 2'd1,
    REQ_SNAPSHOT = 2'd2,
    REQ_TOTALS   = 2'd3
  } req_t;

  localparam logic REG_CHANNEL_COUNT     = 1'b0;
  localparam logic REG_SILENCE_THRESHOLD = 1'b1;

  localparam logic [3:0]  CHANNEL_COUNT_RESET     = 4'd2;
  localparam logic [14:0] SILENCE_THRESHOLD_RESET = 15'd163;

  // Tenths of a percent, doubled so that the quotient rounds half up.
  localparam logic [10:0] TENTHS_SCALE2 = 11'd2000;

  // One report as it leaves the accumulators.
  typedef struct packed {
    logic [31:0] packets;
    logic [31:0] frames;
    logic [31:0] silent;
    logic [63:0] energy;
    logic [15:0] peak;
    logic [31:0] discont;
    logic        sound;
    logic        totals;
  } rec_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? 64'hFFFF_FFFF_FFFF_FFFF : s[63:0];
  endfunction

endpackage

// ----- src/alm_front.sv -----
// Front end: squares samples, gathers packets and folds them into the accumulators.
module alm_front #(
  parameter int MAX_PACKET_FRAMES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] sample,
  input  logic               last_of_packet,
  input  logic [12:0]        frame_count,
  input  logic               discontinuity,
  input  logic [14:0]        silence_threshold,
  output logic               q_push,
  output alm_pkg::rec_t      q_rec,
  input  logic               q_full
);
  import alm_pkg::*;

  // Stage 1: decoded item
  logic        s1_valid;
  req_t        s1_req;
  logic [31:0] s1_sq;
  logic [15:0] s1_mag;
  logic        s1_last;
  logic [12:0] s1_fc;
  logic        s1_disc;

  // Accumulators
  logic [31:0] int_packets, int_frames, int_silent_frames, int_discont;
  logic [63:0] int_energy;
  logic [15:0] int_peak;
  logic [31:0] tot_packets, tot_frames, tot_silent_frames, tot_discont;
  logic [63:0] tot_energy;
  logic [15:0] tot_peak;
  logic [15:0] pkt_peak;
  logic [63:0] pkt_energy;
  logic        sound_flag;

  logic [15:0] mag;
  logic [12:0] fc_clamped;
  logic        s1_report;
  logic        fire;
  logic [63:0] pkt_energy_next;
  logic [15:0] pkt_peak_next;
  logic        loud;
  logic        cnt_en;
  logic        cnt_silent;
  logic        snap_clear;

  always_comb begin
    mag = sample[15] ? (16'h0000 - 16'(sample)) : 16'(sample);
    fc_clamped = (32'(frame_count) > MAX_PACKET_FRAMES) ? 13'(MAX_PACKET_FRAMES) : frame_count;
  end

  assign s1_report = (s1_req == REQ_SNAPSHOT) || (s1_req == REQ_TOTALS);
  assign full      = s1_valid && s1_report && q_full;
  assign fire      = s1_valid && !full;
  assign q_push    = s1_valid && s1_report && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!full) begin
      s1_valid <= push;
    end
    if (push && !full) begin
      s1_req  <= req_t'(req_type);
      s1_mag  <= mag;
      s1_sq   <= {16'h0000, mag} * {16'h0000, mag};
      s1_last <= last_of_packet;
      s1_fc   <= fc_clamped;
      s1_disc <= discontinuity;
    end
  end

  always_comb begin
    pkt_energy_next = sat_add64(pkt_energy, {32'h0, s1_sq});
    pkt_peak_next   = (s1_mag > pkt_peak) ? s1_mag : pkt_peak;
    loud            = pkt_peak_next > {1'b0, silence_threshold};
    cnt_en          = 1'b0;
    cnt_silent      = 1'b0;
    snap_clear      = 1'b0;
    if (fire) begin
      case (s1_req)
        REQ_SAMPLE: begin
          cnt_en     = s1_last;
          cnt_silent = !loud;
        end
        REQ_SILENT: begin
          cnt_en     = 1'b1;
          cnt_silent = 1'b1;
        end
        REQ_SNAPSHOT: snap_clear = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (s1_req == REQ_TOTALS) begin
      q_rec = '{tot_packets, tot_frames, tot_silent_frames, tot_energy, tot_peak,
                tot_discont, sound_flag, 1'b1};
    end else begin
      q_rec = '{int_packets, int_frames, int_silent_frames, int_energy, int_peak,
                int_discont, sound_flag, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      int_packets       <= '0;
      int_frames        <= '0;
      int_silent_frames <= '0;
      int_discont       <= '0;
      int_energy        <= '0;
      int_peak          <= '0;
      tot_packets       <= '0;
      tot_frames        <= '0;
      tot_silent_frames <= '0;
      tot_discont       <= '0;
      tot_energy        <= '0;
      tot_peak          <= '0;
      pkt_peak          <= '0;
      pkt_energy        <= '0;
      sound_flag        <= 1'b0;
    end else begin
      if (fire && s1_req == REQ_SAMPLE) begin
        if (s1_last) begin
          // fold the finished packet in and start afresh
          int_energy <= sat_add64(int_energy, pkt_energy_next);
          tot_energy <= sat_add64(tot_energy, pkt_energy_next);
          if (pkt_peak_next > int_peak) int_peak <= pkt_peak_next;
          if (pkt_peak_next > tot_peak) tot_peak <= pkt_peak_next;
          if (loud) sound_flag <= 1'b1;
          pkt_energy <= '0;
          pkt_peak   <= '0;
        end else begin
          pkt_energy <= pkt_energy_next;
          pkt_peak   <= pkt_peak_next;
        end
      end
      if (cnt_en) begin
        int_packets <= sat_add32(int_packets, 32'd1);
        tot_packets <= sat_add32(tot_packets, 32'd1);
        int_frames  <= sat_add32(int_frames, {19'h0, s1_fc});
        tot_frames  <= sat_add32(tot_frames, {19'h0, s1_fc});
        if (cnt_silent) begin
          int_silent_frames <= sat_add32(int_silent_frames, {19'h0, s1_fc});
          tot_silent_frames <= sat_add32(tot_silent_frames, {19'h0, s1_fc});
        end
        if (s1_disc) begin
          int_discont <= sat_add32(int_discont, 32'd1);
          tot_discont <= sat_add32(tot_discont, 32'd1);
        end
      end
      if (snap_clear) begin
        int_packets       <= '0;
        int_frames        <= '0;
        int_silent_frames <= '0;
        int_discont       <= '0;
        int_energy        <= '0;
        int_peak          <= '0;
      end
    end
  end

endmodule

// ----- src/alm_queue.sv -----
// Two-entry queue of pending reports between front and back end.
module alm_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  alm_pkg::rec_t wr_rec,
  output logic          q_full,
  input  logic          rd,
  output logic          q_valid,
  output alm_pkg::rec_t rd_rec
);
  import alm_pkg::*;

  rec_t        head;
  rec_t        tail;
  logic [1:0]  count;

  assign q_full  = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign rd_rec  = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({wr, rd && q_valid})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
    case (count)
      2'd0: if (wr) head <= wr_rec;
      2'd1: begin
        if (rd && wr) head <= wr_rec;
        else if (wr) tail <= wr_rec;
      end
      2'd2: if (rd) head <= tail;
      default: ;
    endcase
  end

endmodule

// ----- src/alm_back.sv -----
// Back end: works out RMS and silence share of a report by shared divide and root.
module alm_back #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  alm_pkg::rec_t q_rec,
  output logic          q_pop,
  input  logic [3:0]    channel_count,
  output logic          empty,
  input  logic          pop,
  output logic [15:0]   rms_level,
  output logic [15:0]   peak_level,
  output logic [9:0]    silence_tenths,
  output logic [31:0]   packet_total,
  output logic [31:0]   frame_total,
  output logic [31:0]   discontinuity_total,
  output logic          sound_seen,
  output logic          is_totals
);
  import alm_pkg::*;

  localparam int CH_W = $clog2(MAX_CHANNELS + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PREP, S_DIV_RMS, S_SQRT, S_DIV_SIL, S_HOLD
  } state_t;

  state_t      state;
  rec_t        rec;
  logic [31:0] sil;
  logic [31:0] nonsil;
  logic [42:0] ten_num;
  logic [32:0] ten_den;
  logic [63:0] div_num;
  logic [64:0] div_rem;
  logic [63:0] div_den;
  logic [5:0]  step;
  logic [63:0] sq_v;
  logic [63:0] sq_res;
  logic [63:0] sq_bit;
  logic [15:0] rms;
  logic [9:0]  tenths;
  logic        out_valid;
  logic        hold_load;

  logic [CH_W-1:0] ch_eff;
  logic [64:0]     rem_sh;
  logic [63:0]     div_num_next;
  logic [64:0]     div_rem_next;
  logic [63:0]     sq_try;
  logic [63:0]     sq_v_next;
  logic [63:0]     sq_res_next;
  logic [31:0]     sil_in;

  always_comb begin
    if (channel_count == 4'd0) ch_eff = CH_W'(1);
    else if (32'(channel_count) > MAX_CHANNELS) ch_eff = CH_W'(MAX_CHANNELS);
    else ch_eff = CH_W'(channel_count);
    sil_in = (q_rec.silent > q_rec.frames) ? q_rec.frames : q_rec.silent;

    // one restoring divide step
    rem_sh = {div_rem[63:0], div_num[63]};
    if (rem_sh >= {1'b0, div_den}) begin
      div_rem_next = rem_sh - {1'b0, div_den};
      div_num_next = {div_num[62:0], 1'b1};
    end else begin
      div_rem_next = rem_sh;
      div_num_next = {div_num[62:0], 1'b0};
    end

    // one square root step
    sq_try = sq_res + sq_bit;
    if (sq_v >= sq_try) begin
      sq_v_next   = sq_v - sq_try;
      sq_res_next = (sq_res >> 1) + sq_bit;
    end else begin
      sq_v_next   = sq_v;
      sq_res_next = sq_res >> 1;
    end
  end

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign empty     = !out_valid;
  assign hold_load = (state == S_HOLD) && (!out_valid || pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (hold_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            rec    <= q_rec;
            sil    <= sil_in;
            nonsil <= q_rec.frames - sil_in;
            state  <= S_PREP;
          end
        end
        S_PREP: begin
          div_den <= 64'(36'(nonsil) * 36'(ch_eff));
          div_num <= rec.energy;
          div_rem <= '0;
          ten_num <= 43'(sil) * 43'(TENTHS_SCALE2) + 43'(rec.frames);
          ten_den <= {rec.frames, 1'b0};
          step    <= '0;
          state   <= S_DIV_RMS;
        end
        S_DIV_RMS: begin
          div_num <= div_num_next;
          div_rem <= div_rem_next;
          step    <= step + 6'd1;
          if (step == 6'd63) begin
            // no sound frames: report zero
            sq_v   <= (nonsil == 32'd0) ? 64'd0 : div_num_next;
            sq_res <= '0;
            sq_bit <= 64'd1 << 62;
            step   <= '0;
            state  <= S_SQRT;
          end
        end
        S_SQRT: begin
          sq_v   <= sq_v_next;
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          step   <= step + 6'd1;
          if (step == 6'd31) begin
            rms     <= sq_res_next[15:0];
            div_num <= {21'h0, ten_num};
            div_den <= {31'h0, ten_den};
            div_rem <= '0;
            step    <= '0;
            state   <= S_DIV_SIL;
          end
        end
        S_DIV_SIL: begin
          div_num <= div_num_next;
          div_rem <= div_rem_next;
          step    <= step + 6'd1;
          if (step == 6'd63) begin
            tenths <= (rec.frames == 32'd0) ? 10'd0 : div_num_next[9:0];
            state  <= S_HOLD;
          end
        end
        S_HOLD: begin
          if (hold_load) begin
            rms_level           <= rms;
            peak_level          <= rec.peak;
            silence_tenths      <= tenths;
            packet_total        <= rec.packets;
            frame_total         <= rec.frames;
            discontinuity_total <= rec.discont;
            sound_seen          <= rec.sound;
            is_totals           <= rec.totals;
            state               <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/audio_level_meter_top.sv -----
// Top level of the audio level meter: configuration registers and front/back wiring.
//
//  Channel   Handshake              Carries
//  input     push / full            req_type, sample, last_of_packet, frame_count, discontinuity
//  result    empty / pop            rms_level .. is_totals
//  config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Samples and packet markers are taken one per cycle and settle in the cycle after they are taken.
// In the back end a report runs a 64-step restoring divide, a 32-step square root and a
// second 64-step divide on the same divider; two further reports queue behind it.
// Input stalls only when a report meets a full report queue.
// Reset is synchronous; it clears all counters and restores the register defaults.
module audio_level_meter_top #(
  parameter int MAX_CHANNELS      = 8,
  parameter int MAX_PACKET_FRAMES = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [1:0]         req_type,
  input  logic signed [15:0] sample,
  input  logic               last_of_packet,
  input  logic [12:0]        frame_count,
  input  logic               discontinuity,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        rms_level,
  output logic [15:0]        peak_level,
  output logic [9:0]         silence_tenths,
  output logic [31:0]        packet_total,
  output logic [31:0]        frame_total,
  output logic [31:0]        discontinuity_total,
  output logic               sound_seen,
  output logic               is_totals,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import alm_pkg::*;

  logic [3:0]  ch_count;
  logic [14:0] sil_thr;
  logic        q_push;
  logic        q_full;
  logic        q_valid;
  logic        q_pop;
  rec_t        wr_rec;
  rec_t        rd_rec;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_count <= CHANNEL_COUNT_RESET;
      sil_thr  <= SILENCE_THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_CHANNEL_COUNT) ch_count <= cfg_data[3:0];
      else sil_thr <= cfg_data[14:0];
    end
  end

  alm_front #(.MAX_PACKET_FRAMES(MAX_PACKET_FRAMES)) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .req_type          (req_type),
    .sample            (sample),
    .last_of_packet    (last_of_packet),
    .frame_count       (frame_count),
    .discontinuity     (discontinuity),
    .silence_threshold (sil_thr),
    .q_push            (q_push),
    .q_rec             (wr_rec),
    .q_full            (q_full)
  );

  alm_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_rec  (wr_rec),
    .q_full  (q_full),
    .rd      (q_pop),
    .q_valid (q_valid),
    .rd_rec  (rd_rec)
  );

  alm_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
    .clk                 (clk),
    .rst                 (rst),
    .q_valid             (q_valid),
    .q_rec               (rd_rec),
    .q_pop               (q_pop),
    .channel_count       (ch_count),
    .empty               (empty),
    .pop                 (pop),
    .rms_level           (rms_level),
    .peak_level          (peak_level),
    .silence_tenths      (silence_tenths),
    .packet_total        (packet_total),
    .frame_total         (frame_total),
    .discontinuity_total (discontinuity_total),
    .sound_seen          (sound_seen),
    .is_totals           (is_totals)
  );

endmodule

// ----- src/alm_checker.sv -----
// Port-level checks on the audio level meter, bound to its top level.
module alm_checker (
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [15:0] peak_level,
  input logic [9:0]  silence_tenths,
  input logic [31:0] packet_total,
  input logic [31:0] frame_total
);

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(packet_total) && $stable(frame_total))
    else $error("waiting result changed before transfer");

  a_tenths_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> silence_tenths <= 10'd1000)
    else $error("silence share above one thousand tenths");

  a_peak_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> peak_level <= 16'h8000)
    else $error("peak above full scale");

endmodule

bind audio_level_meter_top alm_checker u_alm_checker (.*);
